@@ sv/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg: shared definitions for the LIFO stack with search
// Field widths, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lss_pkg;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 5;

   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

endpackage

@@ sv/lss_store.sv @@
// ----------------------------------------------------------------------------
// lss_store: entry storage for the LIFO stack
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lss_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lifo_stack_with_search.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_with_search: fixed-capacity LIFO stack with indexed read and search
// Push, pop, peek, read at index and search over the held entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge where start is high and busy is
//   low; req_mode selects push, pop, peek, read at index or search. Every
//   request yields exactly one response beat, shown for one cycle with
//   rsp_valid high. The receiver cannot stall, so each response must be
//   captured in the cycle it appears.
//   Push, refused operations and unused modes answer in the cycle after the
//   request. Pop, peek and read at index answer by way of the ST_READ state,
//   since the entry store has a registered read port. A search reads one
//   entry per cycle through the single read port and a shared comparator.
//   busy stays high while a request is in progress, so one request is
//   handled at a time.
//   Reset clears the entry count and the sequencer; the entry store is not
//   cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifo_stack_with_search #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lss_pkg::MODE_W-1:0]    req_mode,
   input  logic [lss_pkg::VALUE_W-1:0]   req_value,
   input  logic [lss_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   output logic [lss_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lss_pkg::DATA_W-1:0]    rsp_data,
   output logic                          rsp_found,
   output logic [lss_pkg::COUNT_W-1:0]   rsp_count,
   output logic                          rsp_is_empty
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int IXW = (CW > lss_pkg::INDEX_W) ? CW : lss_pkg::INDEX_W;
   localparam int XW  = (WIDTH > lss_pkg::VALUE_W) ? WIDTH : lss_pkg::VALUE_W;
   localparam int RW  = (CW > lss_pkg::COUNT_W) ? CW : lss_pkg::COUNT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   lss_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [WIDTH-1:0]   word_ff, word_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lss_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [lss_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [lss_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;
   logic [WIDTH-1:0] rd_data;

   logic [XW-1:0]    value_x;
   logic [WIDTH-1:0] word;
   logic [XW-1:0]    rd_x;
   logic [IXW-1:0]   idx_ext;
   logic [IXW-1:0]   cnt_ext;
   logic [CW-1:0]    count_dec;
   logic [RW-1:0]    cnt_r;
   logic             accept;

   assign busy    = (state_ff != lss_pkg::ST_IDLE);
   assign accept  = start && !busy;

   assign value_x   = XW'(req_value);
   assign word      = value_x[WIDTH-1:0];
   assign rd_x      = XW'(rd_data);
   assign idx_ext   = IXW'(req_index);
   assign cnt_ext   = IXW'(count_ff);
   assign count_dec = count_ff - 1'b1;
   assign wr_addr   = count_ff[AW-1:0];

   lss_store #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      word_in       = word_ff;
      wr_en         = 1'b0;
      rd_addr       = ptr_ff[AW-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = lss_pkg::STATUS_OK;
      rsp_data_in   = '0;
      rsp_found_in  = 1'b0;

      case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  lss_pkg::MODE_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_in = lss_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  lss_pkg::MODE_POP, lss_pkg::MODE_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lss_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr  = count_dec[AW-1:0];
                        state_in = lss_pkg::ST_READ;
                        if (req_mode == lss_pkg::MODE_POP) begin
                           count_in = count_dec;
                        end
                     end
                  end
                  lss_pkg::MODE_READ: begin
                     if (idx_ext >= cnt_ext) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lss_pkg::STATUS_RANGE;
                     end else begin
                        rd_addr  = idx_ext[AW-1:0];
                        state_in = lss_pkg::ST_READ;
                     end
                  end
                  lss_pkg::MODE_SEARCH: begin
                     word_in = word;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr  = '0;
                        ptr_in   = CW'(1);
                        state_in = lss_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         lss_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_x[lss_pkg::DATA_W-1:0];
            state_in     = lss_pkg::ST_IDLE;
         end
         lss_pkg::ST_SCAN: begin
            // The entry compared now was addressed in the previous cycle, so
            // ptr_ff is already one past it.
            if (rd_data == word_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               state_in     = lss_pkg::ST_IDLE;
            end else if (ptr_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = lss_pkg::ST_IDLE;
            end else begin
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = lss_pkg::ST_IDLE;
         end
      endcase

      cnt_r        = RW'(count_in);
      rsp_count_in = cnt_r[lss_pkg::COUNT_W-1:0];
      rsp_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lss_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      word_ff <= word_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while a request is still in progress");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted request neither in progress nor answered");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == lss_pkg::MODE_PUSH && count_ff == FULL_COUNT)
      |=> (count_ff == FULL_COUNT && rsp_status == lss_pkg::STATUS_FULL))
      else $error("push on a full stack was not refused");

endmodule
